// File: hdl/trmah_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trmah_pkg
// Shared types and constants for the touch report map and area hit block.
// ----------------------------------------------------------------------------
package trmah_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned COUNT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_XR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_YR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS  = 2'd3;

  localparam logic [1:0]  ROTATION_RST = 2'd0;
  localparam logic [11:0] TOUCH_XR_RST = 12'd1024;
  localparam logic [11:0] TOUCH_YR_RST = 12'd758;
  localparam logic [15:0] HOLD_MS_RST  = 16'd100;

  localparam logic [1:0] ROT_0 = 2'd0;
  localparam logic [1:0] ROT_1 = 2'd1;
  localparam logic [1:0] ROT_2 = 2'd2;
  localparam logic [1:0] ROT_3 = 2'd3;

  localparam logic [COORD_W-1:0] COORD_MAX = 12'hfff;

  typedef struct packed {
    logic               report_valid;
    logic [47:0]        coord_bytes;
    logic [7:0]         finger_mask;
    logic [31:0]        now_ms;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic               in_area;
    logic [COUNT_W-1:0] finger_count;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0]  rotation;
    logic [11:0] touch_x_resolution;
    logic [11:0] touch_y_resolution;
    logic [15:0] hold_time_ms;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic latch;
    logic result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic need_map;
    logic out_free;
  } ctrl_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_LATCH,
    ST_RESULT
  } state_e;

  function automatic logic [COUNT_W-1:0] popcount8(input logic [7:0] m);
    logic [COUNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + COUNT_W'(m[i]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hdl/trmah_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trmah channel interfaces
// Valid/ready channels for query items, result items and register writes.
// ----------------------------------------------------------------------------
interface trmah_in_if;
  logic                valid;
  logic                ready;
  trmah_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trmah_out_if;
  logic                 valid;
  logic                 ready;
  trmah_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trmah_cfg_if;
  logic               valid;
  logic               ready;
  trmah_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/trmah_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trmah_ctrl
// Sequencer: capture, divider iterations, latch update and result load.
// ----------------------------------------------------------------------------
module trmah_ctrl #(
  parameter int unsigned STEPS = 23
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire trmah_pkg::ctrl_sts_t sts_i,
  output trmah_pkg::ctrl_cmd_t      cmd_o,
  output logic                      in_ready_o
);
  import trmah_pkg::*;

  localparam int unsigned CNT_W = $clog2(STEPS);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic             last_step;

  assign last_step = (cnt_q == CNT_W'(STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_o.div_load) begin
        cnt_q <= '0;
      end else if (cmd_o.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.in_valid) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.need_map ? ST_DIV : ST_RESULT;
      end
      ST_DIV: begin
        if (last_step) state_d = ST_LATCH;
      end
      ST_LATCH: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o.capture  = (state_q == ST_IDLE) && sts_i.in_valid;
    cmd_o.div_load = (state_q == ST_CHECK) && sts_i.need_map;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.latch    = (state_q == ST_LATCH);
    cmd_o.result   = (state_q == ST_RESULT) && sts_i.out_free;
  end

endmodule
`default_nettype wire

// File: hdl/trmah_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trmah_dp
// Datapath: item register, four radix-2 divider lanes, touch latch,
// rectangle hit test and output register.
// ----------------------------------------------------------------------------
module trmah_dp #(
  parameter int unsigned DISPLAY_WIDTH  = 1024,
  parameter int unsigned DISPLAY_HEIGHT = 758,
  parameter int unsigned PROD_W         = 23
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire trmah_pkg::ctrl_cmd_t cmd_i,
  output trmah_pkg::ctrl_sts_t      sts_o,
  input  wire trmah_pkg::cfg_t      cfg_i,
  input  wire logic                 in_valid_i,
  input  wire trmah_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output trmah_pkg::out_item_t      out_item_o
);
  import trmah_pkg::*;

  localparam int unsigned LANES = 4;
  localparam int unsigned SW    = PROD_W + 2;

  in_item_t item_q;

  logic [RAW_W-1:0]  raw [LANES];
  logic [PROD_W-1:0] prod [LANES];
  logic [11:0]       lane_res [LANES];

  logic [PROD_W-1:0] div_q [LANES];
  logic [11:0]       rem_q [LANES];
  logic              zero_q [LANES];
  logic [PROD_W-1:0] quo [LANES];

  logic [31:0]        lat_time_q;
  logic [COUNT_W-1:0] lat_count_q;
  logic [COORD_W-1:0] lat_x_q [2];
  logic [COORD_W-1:0] lat_y_q [2];

  logic [COORD_W-1:0] map_x [2];
  logic [COORD_W-1:0] map_y [2];

  logic               out_valid_q;
  out_item_t          out_q;
  logic               hit;

  function automatic logic [COORD_W-1:0] clamp12(input logic signed [SW-1:0] v);
    logic [COORD_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(SW'(COORD_MAX))) begin
      r = COORD_MAX;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // raw point unpacking: lanes are x0, y0, x1, y1
  always_comb begin
    raw[0] = {item_q.coord_bytes[47:44], item_q.coord_bytes[39:32]};
    raw[1] = {item_q.coord_bytes[43:40], item_q.coord_bytes[31:24]};
    raw[2] = {item_q.coord_bytes[23:20], item_q.coord_bytes[15:8]};
    raw[3] = {item_q.coord_bytes[19:16], item_q.coord_bytes[7:0]};
    prod[0] = PROD_W'(raw[0]) * PROD_W'(DISPLAY_HEIGHT);
    prod[1] = PROD_W'(raw[1]) * PROD_W'(DISPLAY_WIDTH);
    prod[2] = PROD_W'(raw[2]) * PROD_W'(DISPLAY_HEIGHT);
    prod[3] = PROD_W'(raw[3]) * PROD_W'(DISPLAY_WIDTH);
    lane_res[0] = cfg_i.touch_x_resolution;
    lane_res[1] = cfg_i.touch_y_resolution;
    lane_res[2] = cfg_i.touch_x_resolution;
    lane_res[3] = cfg_i.touch_y_resolution;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // one quotient bit per lane per step
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (cmd_i.div_load) begin
        div_q[l]  <= prod[l] - 1'b1;
        rem_q[l]  <= '0;
        zero_q[l] <= (prod[l] == '0);
      end else if (cmd_i.div_step) begin
        logic [12:0] trial;
        logic        ge;
        trial = {rem_q[l], div_q[l][PROD_W-1]};
        ge    = (trial >= {1'b0, lane_res[l]});
        rem_q[l] <= ge ? 12'(trial - {1'b0, lane_res[l]}) : trial[11:0];
        div_q[l] <= {div_q[l][PROD_W-2:0], ge};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (zero_q[l]) begin
        quo[l] = '0;
      end else if (lane_res[l] == '0) begin
        quo[l] = PROD_W'(COORD_MAX);
      end else begin
        quo[l] = div_q[l];
      end
    end
  end

  // rotation and clamp
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      logic signed [SW-1:0] qx, qy, sx, sy;
      qx = $signed({2'b00, quo[2*p]});
      qy = $signed({2'b00, quo[2*p+1]});
      case (cfg_i.rotation)
        ROT_0: begin
          sx = $signed(SW'(DISPLAY_WIDTH - 1)) - qy;
          sy = qx;
        end
        ROT_1: begin
          sx = qx;
          sy = qy;
        end
        ROT_2: begin
          sx = qy;
          sy = $signed(SW'(DISPLAY_HEIGHT - 1)) - qx;
        end
        default: begin
          sx = $signed(SW'(DISPLAY_HEIGHT - 1)) - qx;
          sy = $signed(SW'(DISPLAY_WIDTH - 1)) - qy;
        end
      endcase
      map_x[p] = clamp12(sx);
      map_y[p] = clamp12(sy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_time_q  <= '0;
      lat_count_q <= '0;
      lat_x_q[0]  <= '0;
      lat_x_q[1]  <= '0;
      lat_y_q[0]  <= '0;
      lat_y_q[1]  <= '0;
    end else if (cmd_i.latch) begin
      lat_time_q  <= item_q.now_ms;
      lat_count_q <= popcount8(item_q.finger_mask);
      lat_x_q[0]  <= map_x[0];
      lat_x_q[1]  <= map_x[1];
      lat_y_q[0]  <= map_y[0];
      lat_y_q[1]  <= map_y[1];
    end
  end

  // inclusive rectangle test, edges wrap in 16 bits
  always_comb begin
    logic signed [15:0] right, bottom;
    logic signed [16:0] l17, t17, r17, b17;
    logic               fresh;
    logic               h [2];
    right  = item_q.rect_left + item_q.rect_width;
    bottom = item_q.rect_top + item_q.rect_height;
    l17 = 17'(item_q.rect_left);
    t17 = 17'(item_q.rect_top);
    r17 = 17'(right);
    b17 = 17'(bottom);
    fresh = ((item_q.now_ms - lat_time_q) < {16'd0, cfg_i.hold_time_ms});
    for (int p = 0; p < 2; p++) begin
      logic signed [16:0] x17, y17;
      x17 = $signed({5'd0, lat_x_q[p]});
      y17 = $signed({5'd0, lat_y_q[p]});
      h[p] = (l17 <= x17) && (x17 <= r17) && (t17 <= y17) && (y17 <= b17);
    end
    hit = 1'b0;
    if (fresh) begin
      if (lat_count_q == 4'd1) begin
        hit = h[0];
      end else if (lat_count_q == 4'd2) begin
        hit = h[0] || h[1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      out_q.in_area      <= hit;
      out_q.finger_count <= lat_count_q;
      out_q.first_x      <= lat_x_q[0];
      out_q.first_y      <= lat_y_q[0];
      out_q.second_x     <= lat_x_q[1];
      out_q.second_y     <= lat_y_q[1];
    end
  end

  assign sts_o.in_valid = in_valid_i;
  assign sts_o.need_map = item_q.report_valid && (item_q.finger_mask != 8'd0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule
`default_nettype wire

// File: hdl/touch_report_map_and_area_hit.sv
`default_nettype none
// mapping: the divider runs PROD_W steps, RAW_W plus the bits of the larger
// display span; a query with no valid report or no finger set skips it and
// keeps the latched touch; the four radix-2 divider lanes give one quotient
// bit per cycle for all four coordinates; a result may wait in the output
// register while the next item is taken
// reset: config registers back to defaults, latched touch cleared to zero
// ----------------------------------------------------------------------------
// touch_report_map_and_area_hit
// Maps raw touch reports to screen points, latches them and tests
// rectangle queries against the recent touch.
// ----------------------------------------------------------------------------
module touch_report_map_and_area_hit #(
  parameter int unsigned DISPLAY_WIDTH  = 1024,
  parameter int unsigned DISPLAY_HEIGHT = 758
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  trmah_in_if.sink   req_i,
  trmah_out_if.source rsp_o,
  trmah_cfg_if.sink  cfg_i
);
  import trmah_pkg::*;

  localparam int unsigned SPAN_W = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ?
                                   $clog2(DISPLAY_WIDTH + 1) : $clog2(DISPLAY_HEIGHT + 1);
  localparam int unsigned PROD_W = RAW_W + SPAN_W;

  cfg_t      cfg_q;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // register file
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation           <= ROTATION_RST;
      cfg_q.touch_x_resolution <= TOUCH_XR_RST;
      cfg_q.touch_y_resolution <= TOUCH_YR_RST;
      cfg_q.hold_time_ms       <= HOLD_MS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_ROTATION: cfg_q.rotation           <= cfg_i.data.data[1:0];
        CFG_TOUCH_XR: cfg_q.touch_x_resolution <= cfg_i.data.data[11:0];
        CFG_TOUCH_YR: cfg_q.touch_y_resolution <= cfg_i.data.data[11:0];
        CFG_HOLD_MS:  cfg_q.hold_time_ms       <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  trmah_ctrl #(
    .STEPS (PROD_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (req_i.ready)
  );

  trmah_dp #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .PROD_W         (PROD_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg_q),
    .in_valid_i  (req_i.valid),
    .in_item_i   (req_i.data),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_item_o  (rsp_o.data)
  );

endmodule
`default_nettype wire
